// ===== sv/pmenc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmenc_pkg: shared types and constants for the pad and mouse line encoder
// Holds the transaction structs, the segment phase codes, the segment lengths
// and the leaky integrator used on the mouse accumulators.
// ----------------------------------------------------------------------------
package pmenc_pkg;

  typedef logic [6:0] phase_t;

  // Segment phases of the line transmitter.
  localparam phase_t PH_IDLE      = 7'd0;
  localparam phase_t PH_PAD_START = 7'd1;
  localparam phase_t PH_PAD_BITS  = 7'd2;
  localparam phase_t PH_PAD_END   = 7'd50;
  localparam phase_t PH_PAD_STOP  = 7'd51;
  localparam phase_t PH_REP_GAP   = 7'd52;
  localparam phase_t PH_REP_END   = 7'd53;
  localparam phase_t PH_REP_STOP  = 7'd54;
  localparam phase_t PH_REP_STOP2 = 7'd55;
  localparam phase_t PH_M_START   = 7'd56;
  localparam phase_t PH_M_BITS    = 7'd57;
  localparam phase_t PH_M_STOP    = 7'd95;
  localparam phase_t PH_M_STOP2   = 7'd96;

  // Segment lengths in half-microsecond ticks.
  localparam logic [15:0] T_LEAD       = 16'd18000;
  localparam logic [15:0] T_LEAD_GAP   = 16'd9000;
  localparam logic [15:0] T_LONG       = 16'd2400;
  localparam logic [15:0] T_SHORT      = 16'd800;
  localparam logic [15:0] T_PAD_TAIL   = 16'd34600;
  localparam logic [15:0] T_REP_GAP    = 16'd4200;
  localparam logic [15:0] T_REP_TAIL   = 16'd48500;
  localparam logic [15:0] T_M_LEAD     = 16'd2200;
  localparam logic [15:0] T_M_LEAD_GAP = 16'd750;
  localparam logic [15:0] T_M_ONE_LOW  = 16'd1000;
  localparam logic [15:0] T_M_ZERO_LOW = 16'd276;
  localparam logic [15:0] T_M_ONE_GAP  = 16'd750;
  localparam logic [15:0] T_M_ZERO_GAP = 16'd1470;
  localparam logic [15:0] T_M_STOP     = 16'd176;
  localparam logic [15:0] T_M_TAIL     = 16'd28000;

  localparam logic [5:0] PAD_PIN_MASK = 6'h3F;

  typedef enum logic {
    REQ_EXPIRY = 1'b0,
    REQ_REPORT = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [5:0]        pad_pins;
    logic [2:0]        report_buttons;
    logic signed [7:0] report_dx;
    logic signed [7:0] report_dy;
  } req_t;

  typedef struct packed {
    logic        line_low;
    logic [15:0] period_ticks;
    logic        timer_stop;
  } result_t;

  // acc - (acc >>> 1) + delta, wrapping at 16 bits.
  function automatic logic [15:0] leak(input logic [15:0] acc, input logic [7:0] delta);
    logic [15:0] half;
    begin
      half = 16'($signed(acc) >>> 1);
      leak = acc - half + {{8{delta[7]}}, delta};
    end
  endfunction

endpackage

// ===== sv/pmenc_in_reg.sv =====
// ----------------------------------------------------------------------------
// pmenc_in_reg: input register
// Captures one request transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module pmenc_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            advance,
  input  pmenc_pkg::req_t item_in,
  output logic            valid,
  output pmenc_pkg::req_t item
);
  import pmenc_pkg::*;

  logic valid_next;

  always_comb begin
    if (accept) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

endmodule

// ===== sv/pmenc_core.sv =====
// ----------------------------------------------------------------------------
// pmenc_core: transmitter state and segment logic
// Holds the phase, pad code, mouse packet and accumulators, and works out the
// next line segment for a timer expiry or folds in a mouse report.
// ----------------------------------------------------------------------------
module pmenc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  pmenc_pkg::req_t    item,
  output logic               has_result,
  output pmenc_pkg::result_t result
);
  import pmenc_pkg::*;

  phase_t      phase, phase_next;
  logic [11:0] last_pad_code, last_pad_code_next;
  logic [18:0] mouse_packet, mouse_packet_next;
  logic [15:0] accum_x, accum_x_next;
  logic [15:0] accum_y, accum_y_next;
  logic [2:0]  pending_buttons, pending_buttons_next;

  logic [5:0]  pins_active;
  logic [11:0] pad_code;
  logic [7:0]  mouse_x, mouse_y;
  logic        mouse_send;
  phase_t      pad_step, mouse_step;
  logic [4:0]  pad_pair, mouse_pair;
  logic [3:0]  pad_sel;
  logic        pad_bit, pad_inverted, mouse_bit;

  always_comb begin
    pins_active  = ~item.pad_pins & PAD_PIN_MASK;
    pad_code     = (pins_active != 6'd0) ? {1'b1, 3'b000, pins_active, 2'b00} : 12'd0;
    mouse_x      = 8'(8'd0 - accum_x[7:0]);
    mouse_y      = 8'(8'd0 - accum_y[7:0]);
    mouse_send   = (pending_buttons != 3'd0) || (mouse_x != 8'd0) || (mouse_y != 8'd0);
    pad_step     = phase - PH_PAD_BITS;
    pad_pair     = pad_step[5:1];
    pad_inverted = (pad_pair >= 5'd12);
    pad_sel      = pad_inverted ? 4'(pad_pair - 5'd12) : pad_pair[3:0];
    pad_bit      = (pad_sel <= 4'd11) ? last_pad_code[4'd11 - pad_sel] : 1'b0;
    mouse_step   = phase - PH_M_BITS;
    mouse_pair   = mouse_step[5:1];
    mouse_bit    = (mouse_pair <= 5'd18) ? mouse_packet[5'd18 - mouse_pair] : 1'b0;
  end

  always_comb begin
    phase_next           = phase;
    last_pad_code_next   = last_pad_code;
    mouse_packet_next    = mouse_packet;
    accum_x_next         = accum_x;
    accum_y_next         = accum_y;
    pending_buttons_next = pending_buttons;
    has_result           = 1'b0;
    result               = '0;
    if (item.req_type == REQ_REPORT) begin
      accum_x_next         = leak(accum_x, item.report_dx);
      accum_y_next         = leak(accum_y, item.report_dy);
      pending_buttons_next = pending_buttons | item.report_buttons;
    end else begin
      has_result = 1'b1;
      if (phase == PH_IDLE) begin
        if ((pad_code != 12'd0) || (last_pad_code != 12'd0)) begin
          phase_next         = (pad_code == last_pad_code) ? PH_REP_GAP : PH_PAD_START;
          last_pad_code_next = pad_code;
          result             = '{line_low: 1'b1, period_ticks: T_LEAD, timer_stop: 1'b0};
        end else begin
          // Each check empties the accumulators, whether or not a packet goes out.
          mouse_packet_next    = {~pending_buttons, mouse_x, mouse_y};
          accum_x_next         = 16'd0;
          accum_y_next         = 16'd0;
          pending_buttons_next = 3'd0;
          if (mouse_send) begin
            phase_next = PH_M_START;
            result     = '{line_low: 1'b1, period_ticks: T_M_LEAD, timer_stop: 1'b0};
          end else begin
            result     = '{line_low: 1'b0, period_ticks: 16'd0, timer_stop: 1'b1};
          end
        end
      end else if (phase == PH_PAD_START) begin
        phase_next = PH_PAD_BITS;
        result     = '{line_low: 1'b0, period_ticks: T_LEAD_GAP, timer_stop: 1'b0};
      end else if (phase < PH_PAD_END) begin
        phase_next = phase + 7'd1;
        if (!pad_step[0]) begin
          result = '{line_low: 1'b1, period_ticks: T_SHORT, timer_stop: 1'b0};
        end else begin
          // The second half of the frame sends the complement of the code.
          result = '{line_low: 1'b0,
                     period_ticks: ((pad_bit ^ pad_inverted) ? T_LONG : T_SHORT),
                     timer_stop: 1'b0};
        end
      end else if (phase == PH_PAD_END) begin
        phase_next = PH_PAD_STOP;
        result     = '{line_low: 1'b1, period_ticks: T_SHORT, timer_stop: 1'b0};
      end else if (phase == PH_PAD_STOP) begin
        phase_next = PH_IDLE;
        result     = '{line_low: 1'b0, period_ticks: T_PAD_TAIL, timer_stop: 1'b0};
      end else if (phase == PH_REP_GAP) begin
        phase_next = PH_REP_END;
        result     = '{line_low: 1'b0, period_ticks: T_REP_GAP, timer_stop: 1'b0};
      end else if (phase == PH_REP_END) begin
        phase_next = PH_REP_STOP;
        result     = '{line_low: 1'b1, period_ticks: T_SHORT, timer_stop: 1'b0};
      end else if (phase == PH_REP_STOP) begin
        phase_next = PH_REP_STOP2;
        result     = '{line_low: 1'b0, period_ticks: T_REP_TAIL, timer_stop: 1'b0};
      end else if (phase == PH_REP_STOP2) begin
        phase_next = PH_IDLE;
        result     = '{line_low: 1'b0, period_ticks: T_REP_TAIL, timer_stop: 1'b0};
      end else if (phase == PH_M_START) begin
        phase_next = PH_M_BITS;
        result     = '{line_low: 1'b0, period_ticks: T_M_LEAD_GAP, timer_stop: 1'b0};
      end else if (phase < PH_M_STOP) begin
        phase_next = phase + 7'd1;
        if (!mouse_step[0]) begin
          result = '{line_low: 1'b1,
                     period_ticks: (mouse_bit ? T_M_ONE_LOW : T_M_ZERO_LOW),
                     timer_stop: 1'b0};
        end else begin
          result = '{line_low: 1'b0,
                     period_ticks: (mouse_bit ? T_M_ONE_GAP : T_M_ZERO_GAP),
                     timer_stop: 1'b0};
        end
      end else if (phase == PH_M_STOP) begin
        phase_next = PH_M_STOP2;
        result     = '{line_low: 1'b1, period_ticks: T_M_STOP, timer_stop: 1'b0};
      end else begin
        phase_next = PH_IDLE;
        result     = '{line_low: 1'b0, period_ticks: T_M_TAIL, timer_stop: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      last_pad_code   <= 12'd0;
      mouse_packet    <= 19'd0;
      accum_x         <= 16'd0;
      accum_y         <= 16'd0;
      pending_buttons <= 3'd0;
    end else if (fire) begin
      phase           <= phase_next;
      last_pad_code   <= last_pad_code_next;
      mouse_packet    <= mouse_packet_next;
      accum_x         <= accum_x_next;
      accum_y         <= accum_y_next;
      pending_buttons <= pending_buttons_next;
    end
  end

  a_phase_in_map: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_M_STOP2)
    else $error("transmitter phase left the segment map");

  a_report_keeps_phase: assert property (@(posedge clk) disable iff (rst)
    fire && (item.req_type == REQ_REPORT) |=> $stable(phase))
    else $error("mouse report moved the transmitter phase");

  a_stop_from_idle: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && result.timer_stop |=>
      (phase == PH_IDLE) && (accum_x == 16'd0) && (accum_y == 16'd0)
      && (pending_buttons == 3'd0))
    else $error("timer stop without clearing the mouse state");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    fire && (item.req_type == REQ_EXPIRY) && (phase == PH_IDLE) && result.line_low
      |=> (phase == PH_PAD_START) || (phase == PH_REP_GAP) || (phase == PH_M_START))
    else $error("lead pulse did not open a frame");

endmodule

// ===== sv/pmenc_out_reg.sv =====
// ----------------------------------------------------------------------------
// pmenc_out_reg: result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module pmenc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pmenc_pkg::result_t result_in,
  input  logic               stall,
  output logic               free,
  output logic               valid,
  output pmenc_pkg::result_t result
);
  import pmenc_pkg::*;

  logic valid_next;

  always_comb begin
    free       = !valid || !stall;
    valid_next = load || (valid && stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

// ===== sv/pad_and_mouse_pulse_line_encoder.sv =====
// ----------------------------------------------------------------------------
// pad_and_mouse_pulse_line_encoder: single-line pulse encoder, pad and mouse
// Mouse reports are leaky-integrated into movement accumulators; each timer
// expiry yields the next line level and segment length of a pulse-distance
// pad frame, a repeat frame, a mouse packet, or a timer stop.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  request | req_valid, req_stall | req_type, pad_pins, report_buttons,
//          |                      | report_dx, report_dy
//  result  | rsp_valid, rsp_stall | line_low, period_ticks, timer_stop
//
//  One request transaction is taken every clock cycle while req_stall is low;
//  the rate is set by the single segment-logic pass between the input register
//  and the result register. A timer expiry's result passes through the input
//  register and then the result register, and a mouse report gives none. Reset
//  is synchronous and returns the line to idle with empty accumulators. While
//  the result register is held by rsp_stall, an expiry waits in the input
//  register and req_stall rises; mouse reports still pass through, since they produce no result.
//
module pad_and_mouse_pulse_line_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [5:0]  pad_pins,
  input  logic [2:0]  report_buttons,
  input  logic signed [7:0] report_dx,
  input  logic signed [7:0] report_dy,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        line_low,
  output logic [15:0] period_ticks,
  output logic        timer_stop
);
  import pmenc_pkg::*;

  req_t    req_in;
  req_t    held_req;
  logic    held_valid;
  logic    advance;
  logic    accept;
  logic    core_has_result;
  result_t core_result;
  logic    out_free;
  result_t out_result;

  // Gather the request ports into one transaction word.
  always_comb begin
    req_in = '{req_type: req_type_t'(req_type), pad_pins: pad_pins,
               report_buttons: report_buttons, report_dx: report_dx,
               report_dy: report_dy};
  end

  // The held transaction moves on when it is a report, or when the result
  // register has room for the segment it produces.
  always_comb begin
    advance   = held_valid && ((held_req.req_type == REQ_REPORT) || out_free);
    req_stall = held_valid && !advance;
    accept    = req_valid && !req_stall;
  end

  pmenc_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .advance (advance),
    .item_in (req_in),
    .valid   (held_valid),
    .item    (held_req)
  );

  pmenc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (held_req),
    .has_result (core_has_result),
    .result     (core_result)
  );

  pmenc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && core_has_result),
    .result_in (core_result),
    .stall     (rsp_stall),
    .free      (out_free),
    .valid     (rsp_valid),
    .result    (out_result)
  );

  assign line_low     = out_result.line_low;
  assign period_ticks = out_result.period_ticks;
  assign timer_stop   = out_result.timer_stop;

endmodule
